// ===== design/rm2q_pkg.sv =====
// ----------------------------------------------------------------------------
// rm2q_pkg
// Shared widths, payload structs and branch codes for the matrix-to-quaternion
// core.
// ----------------------------------------------------------------------------
`default_nettype none
package rm2q_pkg;

  localparam int ElemWidth = 16;
  localparam int FracBits  = 14;

  // Trace is at most 3 elements wide plus one; radicand adds one more.
  localparam int RadWidth  = ElemWidth + 3;
  // Scaled radicand fed to the root.
  localparam int SqWidth   = RadWidth + FracBits;
  // Root width: half of the scaled radicand, rounded up.
  localparam int RootWidth = (SqWidth + 1) / 2;
  localparam int RootSteps = RootWidth;
  // Numerators: sum or difference of two elements.
  localparam int NumWidth  = ElemWidth + 1;
  // Dividend magnitude after scaling.
  localparam int DvdWidth  = NumWidth + FracBits;
  localparam int DenWidth  = RootWidth + 1;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_M00   = 2'd1,
    BR_M11   = 2'd2,
    BR_M22   = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [ElemWidth-1:0] m00;
    logic signed [ElemWidth-1:0] m01;
    logic signed [ElemWidth-1:0] m02;
    logic signed [ElemWidth-1:0] m10;
    logic signed [ElemWidth-1:0] m11;
    logic signed [ElemWidth-1:0] m12;
    logic signed [ElemWidth-1:0] m20;
    logic signed [ElemWidth-1:0] m21;
    logic signed [ElemWidth-1:0] m22;
  } in_item_t;

  typedef struct packed {
    logic signed [ElemWidth-1:0] qw;
    logic signed [ElemWidth-1:0] qx;
    logic signed [ElemWidth-1:0] qy;
    logic signed [ElemWidth-1:0] qz;
    logic [1:0]                  branch;
    logic                        invalid;
  } out_item_t;

  // Work carried down the pipe after branch selection.
  typedef struct packed {
    logic [SqWidth-1:0]          rad;     // scaled radicand
    logic signed [NumWidth-1:0]  n0;      // numerators in qw,qx,qy,qz order,
    logic signed [NumWidth-1:0]  n1;      // the slot of the diagonal axis
    logic signed [NumWidth-1:0]  n2;      // is unused
    logic signed [NumWidth-1:0]  n3;
    logic [1:0]                  branch;
    logic                        invalid;
  } work_t;

endpackage
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Rotation matrix to quaternion by the trace / largest-diagonal method.
// ----------------------------------------------------------------------------
// Pipeline: front-end register, root pipeline, divisor/half register, divide
//   pipeline and output register; root and divide resolve one bit per stage, Q2.14 data.
// Throughput: one transaction per cycle; a stall freezes the whole pipe.
// Reset: rst (synchronous) clears all valid bits; payload is not reset.
`default_nettype none
module rotation_matrix_to_quaternion_core (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire rm2q_pkg::in_item_t    in_data,
  output logic                       out_valid,
  input  wire                        out_stall,
  output rm2q_pkg::out_item_t        out_data
);

  localparam int EW = rm2q_pkg::ElemWidth;
  localparam int DW = rm2q_pkg::DvdWidth;
  localparam int RW = rm2q_pkg::RootWidth;

  // Whole pipe advances unless a result sits stalled at the output.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: front end registered.
  rm2q_pkg::work_t f_w, s1_w;
  logic            s1_v;
  rm2q_front u_front (.m(in_data), .w(f_w));
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= in_valid;
    if (adv) s1_w <= f_w;
  end

  // Root pipeline.
  logic            r_v;
  rm2q_pkg::work_t r_w;
  logic [RW-1:0]   r_root;
  rm2q_sqrt u_sqrt (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(s1_v), .in_work(s1_w),
    .out_valid(r_v), .out_work(r_w), .out_root(r_root)
  );

  // Stage after root: divisor and half.
  logic            s2_v;
  rm2q_pkg::work_t s2_w;
  logic [rm2q_pkg::DenWidth-1:0] s2_den;
  logic signed [EW-1:0] s2_half;
  logic [RW-1:0] hr;
  always_comb hr = r_root >> 1;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= r_v;
    if (adv) begin
      s2_w   <= r_w;
      s2_den <= {r_root, 1'b0};
      s2_half <= (RW'(hr) > RW'((1 << (EW-1)) - 1)) ? EW'((1 << (EW-1)) - 1) : EW'(hr);
    end
  end

  // Four dividers; the diagonal slot result is replaced by the half.
  logic signed [EW-1:0] qd [4];
  rm2q_div u_div0 (.clk(clk), .adv(adv), .num(s2_w.n0), .den(s2_den), .quo(qd[0]));
  rm2q_div u_div1 (.clk(clk), .adv(adv), .num(s2_w.n1), .den(s2_den), .quo(qd[1]));
  rm2q_div u_div2 (.clk(clk), .adv(adv), .num(s2_w.n2), .den(s2_den), .quo(qd[2]));
  rm2q_div u_div3 (.clk(clk), .adv(adv), .num(s2_w.n3), .den(s2_den), .quo(qd[3]));

  // Side info delay line matching the dividers.
  logic            dv   [DW+1];
  logic [1:0]      dbr  [DW+1];
  logic            dinv [DW+1];
  logic signed [EW-1:0] dh [DW+1];
  always_comb begin
    dv[0] = s2_v; dbr[0] = s2_w.branch; dinv[0] = s2_w.invalid; dh[0] = s2_half;
  end
  for (genvar i = 0; i < DW; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) dv[i+1] <= 1'b0;
      else if (adv) dv[i+1] <= dv[i];
      if (adv) begin
        dbr[i+1] <= dbr[i]; dinv[i+1] <= dinv[i]; dh[i+1] <= dh[i];
      end
    end
  end

  // Output register.
  rm2q_pkg::out_item_t o;
  always_comb begin
    o.branch  = dbr[DW];
    o.invalid = dinv[DW];
    o.qw = qd[0]; o.qx = qd[1]; o.qy = qd[2]; o.qz = qd[3];
    case (rm2q_pkg::branch_t'(dbr[DW]))
      rm2q_pkg::BR_TRACE: o.qw = dh[DW];
      rm2q_pkg::BR_M00:   o.qx = dh[DW];
      rm2q_pkg::BR_M11:   o.qy = dh[DW];
      rm2q_pkg::BR_M22:   o.qz = dh[DW];
      default:            o.qw = dh[DW];
    endcase
    if (dinv[DW]) begin
      o.qw = '0; o.qx = '0; o.qy = '0; o.qz = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv[DW];
    if (adv) out_data <= o;
  end

endmodule
`default_nettype wire

// ===== design/rm2q_front.sv =====
// ----------------------------------------------------------------------------
// rm2q_front
// Trace, branch choice, radicand and numerators for one matrix.
// ----------------------------------------------------------------------------
`default_nettype none
module rm2q_front (
  input  wire rm2q_pkg::in_item_t m,
  output rm2q_pkg::work_t         w
);

  localparam int RW = rm2q_pkg::RadWidth;
  localparam int NW = rm2q_pkg::NumWidth;

  logic signed [RW-1:0] d0, d1, d2, one, trace, r;
  logic signed [NW-1:0] a00, a01, a02, a10, a12, a20, a21;
  logic signed [NW-1:0] e01, e02, e10, e12, e20, e21;

  always_comb begin
    d0    = RW'(m.m00);
    d1    = RW'(m.m11);
    d2    = RW'(m.m22);
    one   = RW'(1) <<< rm2q_pkg::FracBits;
    trace = d0 + d1 + d2;
    e01 = NW'(m.m01); e02 = NW'(m.m02); e10 = NW'(m.m10);
    e12 = NW'(m.m12); e20 = NW'(m.m20); e21 = NW'(m.m21);
    a21 = e21 - e12;   // m21 - m12
    a02 = e02 - e20;   // m02 - m20
    a10 = e10 - e01;   // m10 - m01
    a01 = e01 + e10;
    a20 = e02 + e20;
    a12 = e12 + e21;
    a00 = '0;
    w.invalid = 1'b0;
    if (trace > 0) begin
      w.branch = rm2q_pkg::BR_TRACE;
      r = trace + one;
      w.n0 = a00; w.n1 = a21; w.n2 = a02; w.n3 = a10;
    end else if (d0 > d1 && d0 > d2) begin
      w.branch = rm2q_pkg::BR_M00;
      r = one + d0 - d1 - d2;
      w.n0 = a21; w.n1 = a00; w.n2 = a01; w.n3 = a20;
    end else if (d1 > d2) begin
      w.branch = rm2q_pkg::BR_M11;
      r = one + d1 - d0 - d2;
      w.n0 = a02; w.n1 = a01; w.n2 = a00; w.n3 = a12;
    end else begin
      w.branch = rm2q_pkg::BR_M22;
      r = one + d2 - d0 - d1;
      w.n0 = a10; w.n1 = a20; w.n2 = a12; w.n3 = a00;
    end
    if (r <= 0) begin
      w.invalid = 1'b1;
      w.rad = '0;
    end else begin
      w.rad = rm2q_pkg::SqWidth'(unsigned'(r)) << rm2q_pkg::FracBits;
    end
  end

endmodule
`default_nettype wire

// ===== design/rm2q_sqrt.sv =====
// ----------------------------------------------------------------------------
// rm2q_sqrt
// Pipelined restoring square root, one root bit per stage, work riding along.
// ----------------------------------------------------------------------------
`default_nettype none
module rm2q_sqrt (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              adv,
  input  wire                              in_valid,
  input  wire rm2q_pkg::work_t             in_work,
  output logic                             out_valid,
  output rm2q_pkg::work_t                  out_work,
  output logic [rm2q_pkg::RootWidth-1:0]   out_root
);

  localparam int N  = rm2q_pkg::RootSteps;
  localparam int RW = rm2q_pkg::RootWidth;
  localparam int MW = rm2q_pkg::RootWidth + 2;   // remainder width

  logic [N:0]                  vld;
  rm2q_pkg::work_t             wk   [N+1];
  logic [2*RW-1:0]             rest [N+1];   // radicand bits not yet consumed
  logic [MW-1:0]               rem  [N+1];
  logic [RW-1:0]               root [N+1];

  always_comb begin
    vld[0]  = in_valid;
    wk[0]   = in_work;
    rest[0] = (2*RW)'(in_work.rad);
    rem[0]  = '0;
    root[0] = '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [MW-1:0] trial, cur;
    // Bring down two radicand bits and try root*4+1.
    always_comb begin
      cur   = {rem[i][MW-3:0], rest[i][2*RW-1 -: 2]};
      trial = cur - {root[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
      if (adv) begin
        wk[i+1]   <= wk[i];
        rest[i+1] <= rest[i] << 2;
        if (!trial[MW-1]) begin
          rem[i+1]  <= trial;
          root[i+1] <= {root[i][RW-2:0], 1'b1};
        end else begin
          rem[i+1]  <= cur;
          root[i+1] <= {root[i][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign out_work  = wk[N];
  assign out_root  = root[N];

endmodule
`default_nettype wire

// ===== design/rm2q_div.sv =====
// ----------------------------------------------------------------------------
// rm2q_div
// Pipelined restoring divider: signed numerator scaled by 2^FracBits over an
// unsigned divisor, truncated toward zero, saturated to the element range.
// ----------------------------------------------------------------------------
`default_nettype none
module rm2q_div (
  input  wire                                    clk,
  input  wire                                    adv,
  input  wire signed [rm2q_pkg::NumWidth-1:0]    num,
  input  wire        [rm2q_pkg::DenWidth-1:0]    den,
  output logic signed [rm2q_pkg::ElemWidth-1:0]  quo
);

  localparam int DW = rm2q_pkg::DvdWidth;
  localparam int VW = rm2q_pkg::DenWidth;
  localparam int EW = rm2q_pkg::ElemWidth;
  localparam int PW = VW + 1;

  logic [DW-1:0] dvd [DW+1];
  logic [DW-1:0] q   [DW+1];
  logic [PW-1:0] rm  [DW+1];
  logic [VW-1:0] dv  [DW+1];
  logic          ng  [DW+1];
  logic [rm2q_pkg::NumWidth-1:0] mag;

  always_comb begin
    mag    = num[rm2q_pkg::NumWidth-1] ? unsigned'(-num) : unsigned'(num);
    dvd[0] = DW'(mag) << rm2q_pkg::FracBits;
    q[0]   = '0;
    rm[0]  = '0;
    dv[0]  = den;
    ng[0]  = num[rm2q_pkg::NumWidth-1];
  end

  // One quotient bit per stage.
  for (genvar i = 0; i < DW; i++) begin : g_step
    logic [PW-1:0] cur, trial;
    always_comb begin
      cur   = {rm[i][PW-2:0], dvd[i][DW-1]};
      trial = cur - PW'(dv[i]);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dvd[i+1] <= dvd[i] << 1;
        dv[i+1]  <= dv[i];
        ng[i+1]  <= ng[i];
        if (!trial[PW-1]) begin
          rm[i+1] <= trial;
          q[i+1]  <= {q[i][DW-2:0], 1'b1};
        end else begin
          rm[i+1] <= cur;
          q[i+1]  <= {q[i][DW-2:0], 1'b0};
        end
      end
    end
  end

  // Saturate and apply sign.
  localparam logic [DW:0] Lim = (DW+1)'(1) << (EW-1);
  logic [DW:0] qe, qs;
  always_comb begin
    qe = {1'b0, q[DW]};
    if (ng[DW]) begin
      qs  = (qe > Lim) ? Lim : qe;
      quo = EW'(-qs);
    end else begin
      qs  = (qe > Lim - 1) ? Lim - 1 : qe;
      quo = EW'(qs);
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the matrix-to-quaternion core against a bit-exact model of the
// trace / largest-diagonal conversion under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  rm2q_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  rm2q_pkg::out_item_t out_data;

  rm2q_pkg::out_item_t quat_queue[$];
  int        n_errors;
  bit        stall_busy;
  int        stall_left = 0;

  localparam int Latency = 51;

  rotation_matrix_to_quaternion_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #4ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Gap length: mostly short, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Integer square root, floored
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // Scaled, truncated, saturated quotient
  function automatic logic [rm2q_pkg::ElemWidth-1:0] quot(longint num,
                                                         longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag << rm2q_pkg::FracBits) / den;
    if (num < 0) begin
      if (q > 32768) q = 32768;
      return rm2q_pkg::ElemWidth'(-longint'(q));
    end
    if (q > 32767) q = 32767;
    return rm2q_pkg::ElemWidth'(q);
  endfunction

  function automatic rm2q_pkg::out_item_t quat_of(rm2q_pkg::in_item_t a);
    rm2q_pkg::out_item_t r;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22, tr, rad, one;
    longint unsigned rt, den;
    logic [rm2q_pkg::ElemWidth-1:0] half;
    m00 = a.m00; m01 = a.m01; m02 = a.m02;
    m10 = a.m10; m11 = a.m11; m12 = a.m12;
    m20 = a.m20; m21 = a.m21; m22 = a.m22;
    one = 64'd1 << rm2q_pkg::FracBits;
    r = '0;
    tr = m00 + m11 + m22;
    if (tr > 0) begin
      rt = isqrt(longint'(tr + one) << rm2q_pkg::FracBits);
      den = rt * 2;
      r.branch = rm2q_pkg::BR_TRACE;
      r.qw = rm2q_pkg::ElemWidth'(((rt >> 1) > 32767) ? 32767 : (rt >> 1));
      r.qx = quot(m21 - m12, den);
      r.qy = quot(m02 - m20, den);
      r.qz = quot(m10 - m01, den);
    end else begin
      if (m00 > m11 && m00 > m22) begin
        r.branch = rm2q_pkg::BR_M00; rad = one + m00 - m11 - m22;
      end else if (m11 > m22) begin
        r.branch = rm2q_pkg::BR_M11; rad = one + m11 - m00 - m22;
      end else begin
        r.branch = rm2q_pkg::BR_M22; rad = one + m22 - m00 - m11;
      end
      if (rad <= 0) begin
        r.invalid = 1'b1;
      end else begin
        rt = isqrt(longint'(rad) << rm2q_pkg::FracBits);
        den = rt * 2;
        half = rm2q_pkg::ElemWidth'(((rt >> 1) > 32767) ? 32767 : (rt >> 1));
        case (r.branch)
          rm2q_pkg::BR_M00: begin
            r.qw = quot(m21 - m12, den); r.qx = half;
            r.qy = quot(m01 + m10, den); r.qz = quot(m02 + m20, den);
          end
          rm2q_pkg::BR_M11: begin
            r.qw = quot(m02 - m20, den); r.qx = quot(m01 + m10, den);
            r.qy = half; r.qz = quot(m12 + m21, den);
          end
          default: begin
            r.qw = quot(m10 - m01, den); r.qx = quot(m02 + m20, den);
            r.qy = quot(m12 + m21, den); r.qz = half;
          end
        endcase
      end
    end
    return r;
  endfunction

  // Send one transaction and queue its expected quaternion
  task automatic send_matrix(rm2q_pkg::in_item_t a);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    quat_queue.push_back(quat_of(a));
  endtask

  // Receiver stall pattern: runs of stall, mostly short, a few long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stall_busy && ($urandom_range(0, 99) < 30)) begin
      stall_left <= gap_len();
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    rm2q_pkg::out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (quat_queue.size() == 0) begin
        $error("unexpected transaction %h", out_data);
        n_errors++;
      end else begin
        e = quat_queue.pop_front();
        if (out_data.qw !== e.qw) begin
          $error("qw exp %0d got %0d", e.qw, out_data.qw); n_errors++;
        end
        if (out_data.qx !== e.qx) begin
          $error("qx exp %0d got %0d", e.qx, out_data.qx); n_errors++;
        end
        if (out_data.qy !== e.qy) begin
          $error("qy exp %0d got %0d", e.qy, out_data.qy); n_errors++;
        end
        if (out_data.qz !== e.qz) begin
          $error("qz exp %0d got %0d", e.qz, out_data.qz); n_errors++;
        end
        if (out_data.branch !== e.branch) begin
          $error("branch exp %0d got %0d", e.branch, out_data.branch); n_errors++;
        end
        if (out_data.invalid !== e.invalid) begin
          $error("invalid exp %0d got %0d", e.invalid, out_data.invalid); n_errors++;
        end
      end
    end
  end

  function automatic rm2q_pkg::in_item_t diag(int d0, int d1, int d2);
    rm2q_pkg::in_item_t a;
    a = '0;
    a.m00 = rm2q_pkg::ElemWidth'(d0);
    a.m11 = rm2q_pkg::ElemWidth'(d1);
    a.m22 = rm2q_pkg::ElemWidth'(d2);
    return a;
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom());
  endfunction

  // Random element in [-r, r]
  function automatic logic [15:0] rnd_in(int r);
    return 16'(int'($urandom_range(0, 2*r)) - r);
  endfunction

  // Random rotation-like matrix: diagonal in [-16384, 16384], off-diagonal noise in [-4096, 4096]
  function automatic rm2q_pkg::in_item_t rot_like();
    rm2q_pkg::in_item_t a;
    int s;
    s = 4096;
    a.m00 = rnd_in(16384); a.m01 = rnd_in(s); a.m02 = rnd_in(s);
    a.m10 = rnd_in(s);     a.m11 = rnd_in(16384); a.m12 = rnd_in(s);
    a.m20 = rnd_in(s);     a.m21 = rnd_in(s); a.m22 = rnd_in(16384);
    return a;
  endfunction

  task automatic test_directed();
    rm2q_pkg::in_item_t a;
    send_matrix(diag(16384, 16384, 16384));      // identity
    send_matrix(diag(16384, -16384, -16384));    // m00 largest
    send_matrix(diag(-16384, 16384, -16384));    // m11 largest
    send_matrix(diag(-16384, -16384, 16384));    // m22 largest
    send_matrix(diag(0, 0, 0));                  // zero trace, all tied
    send_matrix(diag(-100, -100, -200));         // m00 ties m11
    send_matrix(diag(-200, -100, -100));         // m11 ties m22
    send_matrix(diag(-32768, -32768, -32768));   // most negative diagonal, all tied
    send_matrix(diag(-16384, -16384, -16384));   // all tied at -1
    send_matrix(diag(32767, 32767, 32767));      // largest trace
    send_matrix(diag(1, 0, 0));                  // smallest positive trace
    a = '1;
    send_matrix(a);
    a = {9{16'sh8000}};
    send_matrix(a);
    a = {9{16'sh7fff}};
    send_matrix(a);
    a = diag(0, -32768, -32768);                 // m00 branch with extreme off-diagonals
    a.m01 = 16'sh7fff; a.m10 = 16'sh7fff; a.m02 = 16'sh8000; a.m20 = 16'sh8000;
    send_matrix(a);
    a = diag(32767, -32768, -32768);
    a.m12 = 16'sh8000; a.m21 = 16'sh7fff;
    send_matrix(a);
  endtask

  task automatic test_random(int n);
    rm2q_pkg::in_item_t a;
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        a = {rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
             rnd16(), rnd16(), rnd16()};
      end else begin
        a = rot_like();
      end
      send_matrix(a);
    end
  endtask

  task automatic test_backpressure(int n);
    stall_busy = 1'b1;
    test_random(n);
    stall_busy = 1'b0;
  endtask

  initial begin
    int guard;
    n_errors   = 0;
    stall_busy = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    stall_busy = 1'b1;
    test_directed();
    stall_busy = 1'b0;
    test_random(500);
    test_backpressure(800);
    in_valid <= 1'b0;

    guard = 0;
    while (quat_queue.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (Latency + 10) @(posedge clk);
    if (quat_queue.size() != 0) begin
      $error("%0d transactions never arrived", quat_queue.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
